FILE: rtl/rsdp_ss_pkg.sv
package rsdp_ss_pkg;

   localparam int unsigned POS_W      = 6;
   localparam int unsigned ALIGN_BITS = 4;
   localparam int unsigned SEL_W      = 2;

   localparam logic [SEL_W-1:0] LANE_FIRST = 2'd0;
   localparam logic [SEL_W-1:0] LANE_LAST  = 2'd2;

   localparam logic [POS_W-1:0] SIG_LEN    = 6'd8;
   localparam logic [POS_W-1:0] REV_POS    = 6'd15;
   localparam logic [POS_W-1:0] SHORT_LAST = 6'd19;
   localparam logic [POS_W-1:0] LONG_LAST  = 6'd35;
   localparam logic [7:0]       LONG_REV   = 8'd2;

   localparam logic [31:0] BASE_RESET = 32'h000e_0000;
   localparam logic [63:0] SIG_TEXT   = "RSD PTR ";

   typedef struct packed {
      logic             active;
      logic             sig_ok;
      logic             is_long;
      logic [7:0]       sum;
      logic [POS_W-1:0] pos;
   } lane_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] res;
      unique case (idx)
         3'd0: res = SIG_TEXT[63:56];
         3'd1: res = SIG_TEXT[55:48];
         3'd2: res = SIG_TEXT[47:40];
         3'd3: res = SIG_TEXT[39:32];
         3'd4: res = SIG_TEXT[31:24];
         3'd5: res = SIG_TEXT[23:16];
         3'd6: res = SIG_TEXT[15:8];
         3'd7: res = SIG_TEXT[7:0];
         default: res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/rsdp_signature_scanner_core.sv
// Scans a region of firmware memory for the ACPI root pointer structure.
// The req channel carries one memory byte per word, in address order, with
// first_byte marking the start of a new scan and last_byte its final byte.
// A candidate opens at every 16-byte boundary; three lanes follow the
// overlapping candidates, checking the signature and the byte checksum over
// 20 or 36 bytes as the revision byte selects.
// The rsp channel gives at most one word per scan: found with the region base
// plus the candidate's offset, or not-found on the final byte of the region.
// Bytes after a result are discarded until the next first_byte.
// Each byte passes through one stage of logic into the output register, so a
// result appears in the cycle after the byte that completes it, and one byte is
// taken every cycle while the output register is empty or being drained.
// When the receiver stalls with a result held, req_ready falls and the scan
// waits. Reset empties the output register, restarts the scan at offset zero
// and loads region_base with its default; csr writes update region_base.
module rsdp_signature_scanner_core #(
   parameter int unsigned REGION_BYTES = 131072
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_rsdp_address,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);

   localparam int unsigned OFF_W = $clog2(REGION_BYTES);
   localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(REGION_BYTES - 1);
   localparam int unsigned LANES = 3;

   logic [31:0]                     region_base_ff;
   logic [OFF_W-1:0]                byte_offset_ff, byte_offset_in;
   logic [rsdp_ss_pkg::SEL_W-1:0]   lane_sel_ff, lane_sel_in;
   logic                            scan_done_ff, scan_done_in;
   rsdp_ss_pkg::lane_type           lane_ff [LANES];
   rsdp_ss_pkg::lane_type           lane_in [LANES];
   logic [OFF_W-1:0]                lane_start_ff [LANES];
   logic [OFF_W-1:0]                lane_start_in [LANES];
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [31:0]                     rsp_address_ff, rsp_address_in;

   logic                            take;
   logic [OFF_W-1:0]                cur_offset;
   logic [rsdp_ss_pkg::SEL_W-1:0]   cur_sel;
   logic                            cur_done;
   logic                            open_lane;
   logic                            scan_end;
   logic                            hit;
   logic                            produce;
   logic [OFF_W-1:0]                hit_start;
   logic [LANES-1:0]                cur_active;
   logic [LANES-1:0]                finish;
   logic [LANES-1:0]                pass;

   assign req_ready        = !rsp_valid_ff || rsp_ready;
   assign take             = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_rsdp_address = rsp_address_ff;

   assign cur_offset = req_first_byte ? '0 : byte_offset_ff;
   assign cur_sel    = req_first_byte ? rsdp_ss_pkg::LANE_FIRST : lane_sel_ff;
   assign cur_done   = req_first_byte ? 1'b0 : scan_done_ff;
   assign open_lane  = (cur_offset[rsdp_ss_pkg::ALIGN_BITS-1:0] == '0);
   assign scan_end   = req_last_byte || (cur_offset >= LAST_OFF);

   always_comb begin
      rsdp_ss_pkg::lane_type lane;
      for (int k = 0; k < LANES; k++) begin
         lane = lane_ff[k];
         lane_start_in[k] = lane_start_ff[k];
         if (req_first_byte) begin
            lane.active = 1'b0;
         end
         cur_active[k] = lane.active;
         if (open_lane && (cur_sel == rsdp_ss_pkg::SEL_W'(k))) begin
            lane = '{active: 1'b1, sig_ok: 1'b1, is_long: 1'b0, sum: 8'h00, pos: '0};
            lane_start_in[k] = cur_offset;
         end
         finish[k] = 1'b0;
         pass[k]   = 1'b0;
         if (lane.active) begin
            lane.sum = lane.sum + req_data_byte;
            if ((lane.pos < rsdp_ss_pkg::SIG_LEN) &&
                (req_data_byte != rsdp_ss_pkg::sig_byte(lane.pos[2:0]))) begin
               lane.sig_ok = 1'b0;
            end
            if (lane.pos == rsdp_ss_pkg::REV_POS) begin
               lane.is_long = (req_data_byte >= rsdp_ss_pkg::LONG_REV);
            end
            if (lane.pos >= (lane.is_long ? rsdp_ss_pkg::LONG_LAST
                                          : rsdp_ss_pkg::SHORT_LAST)) begin
               finish[k]   = 1'b1;
               pass[k]     = lane.sig_ok && (lane.sum == 8'h00);
               lane.active = 1'b0;
            end
            lane.pos = lane.pos + 1'b1;
         end
         lane_in[k] = lane;
      end
   end

   // Two lanes can only pass together when one closes a long span and the
   // other a short one; the long one opened first and so has the lower offset.
   always_comb begin
      logic got_long;
      logic got_any;
      got_long  = 1'b0;
      got_any   = 1'b0;
      hit_start = '0;
      for (int k = 0; k < LANES; k++) begin
         if (pass[k] && lane_in[k].is_long && !got_long) begin
            got_long  = 1'b1;
            hit_start = lane_start_in[k];
         end
      end
      for (int k = 0; k < LANES; k++) begin
         if (pass[k] && !got_long && !got_any) begin
            got_any   = 1'b1;
            hit_start = lane_start_in[k];
         end
      end
   end

   assign hit     = |pass;
   assign produce = !cur_done && (hit || scan_end);

   always_comb begin
      byte_offset_in = cur_offset + 1'b1;
      lane_sel_in    = cur_sel;
      if (open_lane) begin
         lane_sel_in = (cur_sel == rsdp_ss_pkg::LANE_LAST) ? rsdp_ss_pkg::LANE_FIRST
                                                           : cur_sel + 1'b1;
      end
      scan_done_in   = produce;
      rsp_found_in   = hit;
      rsp_address_in = hit ? region_base_ff + 32'(hit_start) : 32'h0000_0000;
      if (take && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= rsdp_ss_pkg::BASE_RESET;
      end else if (csr_write_en) begin
         region_base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff <= '0;
         lane_sel_ff    <= rsdp_ss_pkg::LANE_FIRST;
         scan_done_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int k = 0; k < LANES; k++) begin
            lane_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take && !cur_done) begin
            byte_offset_ff <= byte_offset_in;
            lane_sel_ff    <= lane_sel_in;
            scan_done_ff   <= scan_done_in;
            for (int k = 0; k < LANES; k++) begin
               lane_ff[k] <= lane_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && !cur_done) begin
         for (int k = 0; k < LANES; k++) begin
            lane_start_ff[k] <= lane_start_in[k];
         end
      end
      if (take && produce) begin
         rsp_found_ff   <= rsp_found_in;
         rsp_address_ff <= rsp_address_in;
      end
   end

`ifndef SYNTH
   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      take && produce |=> scan_done_ff)
      else $error("scan not closed after its result");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_address_ff == 32'h0000_0000)
      else $error("not-found result carries an address");

   a_lane_free_on_open: assert property (@(posedge clock) disable iff (reset)
      take && !cur_done && open_lane |->
         !((cur_sel == 2'd0 && cur_active[0]) || (cur_sel == 2'd1 && cur_active[1]) ||
           (cur_sel == 2'd2 && cur_active[2])))
      else $error("lane reopened while still busy");

   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      lane_sel_ff != 2'd3)
      else $error("lane selector out of range");

   a_two_finish: assert property (@(posedge clock) disable iff (reset)
      take && !cur_done |-> $countones(finish) <= 2)
      else $error("more than two lanes closed on one word");
`endif

endmodule

FILE: verif/rsdp_scan_checker.sv
`timescale 1ns / 1ps

module rsdp_scan_checker #(
   parameter int unsigned REGION_BYTES = 131072
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_found,
   input  logic [31:0] rsp_rsdp_address,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   output int unsigned fail_count,
   output int unsigned pending_results
);

   localparam int unsigned LANES = 3;

   typedef struct packed {
      logic        found;
      logic [31:0] address;
   } pointer_word_type;

   pointer_word_type pointer_q[$];

   logic [31:0] base_q;
   logic [16:0] next_offset;
   logic [7:0]  lane_sum   [LANES];
   logic [16:0] lane_start [LANES];
   logic        lane_open  [LANES];
   logic        lane_sig   [LANES];
   logic        lane_long  [LANES];
   logic        scan_done;

   task automatic clear_scan();
      next_offset = '0;
      scan_done   = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         lane_sum[k]   = '0;
         lane_start[k] = '0;
         lane_open[k]  = 1'b0;
         lane_sig[k]   = 1'b0;
         lane_long[k]  = 1'b0;
      end
   endtask

   task automatic scan_byte(input logic [7:0] data, input logic first, input logic last);
      logic [16:0] off;
      logic [16:0] pos;
      logic        ends;
      logic        hit;
      logic [16:0] hit_start;
      int unsigned lane;
      int unsigned sig_idx;
      if (first) clear_scan();
      if (!scan_done) begin
         off       = next_offset;
         ends      = last || (off >= REGION_BYTES - 1);
         hit       = 1'b0;
         hit_start = '0;
         if (off[rsdp_ss_pkg::ALIGN_BITS-1:0] == '0) begin
            lane             = (off >> rsdp_ss_pkg::ALIGN_BITS) % LANES;
            lane_open[lane]  = 1'b1;
            lane_start[lane] = off;
            lane_sum[lane]   = '0;
            lane_sig[lane]   = 1'b1;
            lane_long[lane]  = 1'b0;
         end
         for (int k = 0; k < LANES; k++) begin
            if (lane_open[k]) begin
               pos         = off - lane_start[k];
               lane_sum[k] = lane_sum[k] + data;
               if (pos < rsdp_ss_pkg::SIG_LEN) begin
                  sig_idx = 7 - pos[2:0];
                  if (data != rsdp_ss_pkg::SIG_TEXT[8*sig_idx +: 8]) lane_sig[k] = 1'b0;
               end
               if (pos == rsdp_ss_pkg::REV_POS) lane_long[k] = (data >= rsdp_ss_pkg::LONG_REV);
               if (pos >= (lane_long[k] ? rsdp_ss_pkg::LONG_LAST
                                        : rsdp_ss_pkg::SHORT_LAST)) begin
                  lane_open[k] = 1'b0;
                  if (lane_sig[k] && lane_sum[k] == 8'd0 &&
                      (!hit || lane_start[k] < hit_start)) begin
                     hit       = 1'b1;
                     hit_start = lane_start[k];
                  end
               end
            end
         end
         if (next_offset < REGION_BYTES) next_offset = next_offset + 1'b1;
         if (hit) begin
            scan_done = 1'b1;
            pointer_q.push_back('{found: 1'b1, address: base_q + {15'd0, hit_start}});
         end else if (ends) begin
            scan_done = 1'b1;
            for (int k = 0; k < LANES; k++) lane_open[k] = 1'b0;
            pointer_q.push_back('{found: 1'b0, address: 32'd0});
         end
      end
   endtask

   always @(posedge clock) begin
      pointer_word_type want;
      if (reset) begin
         base_q     = rsdp_ss_pkg::BASE_RESET;
         fail_count = 0;
         clear_scan();
         pointer_q.delete();
      end else begin
         if (csr_write_en) base_q = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (pointer_q.size() == 0) begin
               $error("rsp word with nothing expected: found %0d, rsdp_address %h",
                      rsp_found, rsp_rsdp_address);
               fail_count++;
            end else begin
               want = pointer_q.pop_front();
               if (rsp_found !== want.found) begin
                  $error("rsp_found: expected %0d, got %0d", want.found, rsp_found);
                  fail_count++;
               end
               if (rsp_rsdp_address !== want.address) begin
                  $error("rsp_rsdp_address: expected %h, got %h",
                         want.address, rsp_rsdp_address);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) scan_byte(req_data_byte, req_first_byte, req_last_byte);
      end
      pending_results = pointer_q.size();
   end

endmodule

FILE: verif/tb_rsdp_signature_scanner_core.sv
`timescale 1ns / 1ps

module tb_rsdp_signature_scanner_core;

   // A small region keeps the scans that run into the region limit short.
   localparam int unsigned REGION_BYTES = 192;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HOLD_CYCLES  = 200;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte  = 8'd0;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic        rsp_found;
   logic [31:0] rsp_rsdp_address;
   logic        csr_write_en   = 1'b0;
   logic [31:0] csr_write_data = 32'd0;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned cycle_count = 0;
   int unsigned items_sent  = 0;
   logic        send_calm   = 1'b0;
   logic [7:0]  image [0:255];

   rsdp_signature_scanner_core #(
      .REGION_BYTES(REGION_BYTES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_rsdp_address(rsp_rsdp_address),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   rsdp_scan_checker #(
      .REGION_BYTES(REGION_BYTES)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_rsdp_address(rsp_rsdp_address),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL rsdp_signature_scanner_core");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(16, 48);
      if (r < 92) return $urandom_range(49, 130);
      if (r < 97) return $urandom_range(131, REGION_BYTES - 1);
      return $urandom_range(REGION_BYTES, REGION_BYTES + 8);
   endfunction

   task automatic send_word(input logic [7:0] data, input logic first, input logic last);
      int unsigned gap;
      gap = send_calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_first_byte <= first;
      req_last_byte  <= last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic fill_image();
      for (int i = 0; i < 256; i++) image[i] = 8'($urandom);
   endtask

   // The checksum byte at offset 8 is chosen so that the whole span sums to zero.
   task automatic plant_pointer(input int unsigned at, input logic [7:0] rev);
      logic [7:0]  acc;
      int unsigned span;
      for (int i = 0; i < 8; i++) image[at+i] = rsdp_ss_pkg::SIG_TEXT[8*(7-i) +: 8];
      for (int i = 9; i < 15; i++) image[at+i] = 8'($urandom);
      image[at+15] = rev;
      span = (rev >= rsdp_ss_pkg::LONG_REV) ? rsdp_ss_pkg::LONG_LAST + 1
                                            : rsdp_ss_pkg::SHORT_LAST + 1;
      acc  = 8'd0;
      for (int i = 0; i < span; i++) if (i != 8) acc = acc + image[at+i];
      image[at+8] = 8'd0 - acc;
   endtask

   // Candidates are planted from the top down, so that each one only rewrites
   // bytes lying below the spans of those already in place.
   task automatic build_scan(input int unsigned len);
      int          at;
      int unsigned r;
      logic [7:0]  rev;
      fill_image();
      for (at = int'((len - 1) & ~32'd15); at >= 0; at -= 16) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            plant_pointer(at + 16, 8'($urandom_range(0, 1)));
            plant_pointer(at, 8'($urandom_range(2, 255)));
         end else if (r < 40) begin
            case ($urandom_range(0, 5))
               0:       rev = 8'd0;
               1:       rev = 8'd1;
               2:       rev = 8'd2;
               3:       rev = 8'hff;
               default: rev = 8'($urandom);
            endcase
            plant_pointer(at, rev);
         end
      end
      if ($urandom_range(0, 3) == 0)
         image[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
   endtask

   task automatic stream_scan(input int unsigned len, input logic mark_first,
                              input logic mark_last);
      send_calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++)
         send_word(image[i], mark_first && i == 0, mark_last && i == len - 1);
   endtask

   initial begin : drain_side
      int unsigned round;
      int unsigned off_len;
      round = 0;
      @(posedge clock);
      forever begin
         if (round % 150 == 75) off_len = HOLD_CYCLES;
         else if (round % 40 < 8) off_len = 0;
         else off_len = pick_gap();
         if (off_len != 0) begin
            rsp_ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         round++;
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned len;
      int unsigned waited;
      logic        mark_first;
      logic        mark_last;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Straight after reset, with no first mark: a valid pointer whose last
      // checksum byte is also the region's last byte, then a word after the
      // result, then a scan of a single byte.
      fill_image();
      plant_pointer(0, 8'd0);
      stream_scan(20, 1'b0, 1'b1);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b1, 1'b1);

      phase = 0;
      while (items_sent < 1450) begin
         wait_idle();
         csr_write_en <= 1'b1;
         case (phase % 4)
            0:       csr_write_data <= 32'h0000_0000;
            1:       csr_write_data <= 32'hffff_ffff;
            default: csr_write_data <= $urandom;
         endcase
         @(posedge clock);
         csr_write_en <= 1'b0;
         for (int s = 0; s < 5; s++) begin
            if ($urandom_range(0, 99) < 8) begin
               send_calm = 1'b0;
               repeat ($urandom_range(1, 8))
                  send_word(8'($urandom), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 3) == 0);
            end else begin
               len = pick_len();
               build_scan(len);
               mark_first = ($urandom_range(0, 19) != 0);
               if (len < REGION_BYTES) mark_last = ($urandom_range(0, 19) != 0);
               else mark_last = $urandom_range(0, 1);
               stream_scan(len, mark_first, mark_last);
            end
            if ($urandom_range(0, 9) == 0) wait_idle();
         end
         phase++;
      end

      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (pending_results != 0 && waited < 5000);
      repeat (10) @(posedge clock);
      if (pending_results != 0) $error("%0d expected words never arrived", pending_results);
      if (fail_count == 0 && pending_results == 0) begin
         $display("PASS rsdp_signature_scanner_core");
      end else begin
         $display("FAIL rsdp_signature_scanner_core");
      end
      $finish;
   end

endmodule
